### design/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Types and constants for the colour triangle score unit.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int ChanW   = 8;
	localparam int PointW  = 24;
	localparam int DiffW   = 9;
	localparam int DistW   = 18;
	localparam int CrossW  = 19;
	localparam int AreaW   = 36;
	localparam int ProdW   = 36;
	localparam int DenW    = 54;
	localparam int NumW    = 38;
	localparam int FracW   = 16;
	localparam int QuotW   = 18;
	localparam int RadW    = 66;
	localparam int RootW   = 33;
	localparam int RemW    = 36;
	localparam int DivRemW = DenW + QuotW;
	localparam int ScoreW  = 34;
	localparam int Steps   = RootW;

	typedef enum logic [1:0] {
		MODE_ZERO  = 2'd0,
		MODE_INVSQ = 2'd1,
		MODE_PERIM = 2'd2,
		MODE_AREA  = 2'd3
	} mode_t;

	typedef logic signed [DiffW-1:0] diff3_t [3];

	typedef struct packed {
		logic                valid;
		mode_t               mode;
		logic                flag;
		logic [2:0][RemW-1:0]  rem;
		logic [2:0][RootW-1:0] root;
		logic [2:0][RadW-1:0]  rad;
		logic [DivRemW-1:0]  drem;
		logic [DenW-1:0]     den;
		logic [QuotW-1:0]    quot;
	} iter_t;

endpackage

### design/color_triangle_score_unit.sv
// ----------------------------------------------------------------------------
// color_triangle_score_unit
// Fully pipelined triangle score over three rgb points; one transaction per
// clock, result strobed on done after the digit stages and output register.
// ----------------------------------------------------------------------------
// busy is always low: a transaction can be started on every clock and the
// result for it appears on score and coincident_pair, with done high for one
// cycle, in start order. The result passes through five stages of input,
// difference, distance, cross product and product arithmetic, then the 33
// square root digit stages (one result bit per stage), then the output
// register. The receiver cannot stall the unit. The mode set over cfg_data is
// sampled with each start and cfg_ready is always high.
module color_triangle_score_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cts_pkg::PointW-1:0]    point_a,
	input  logic [cts_pkg::PointW-1:0]    point_b,
	input  logic [cts_pkg::PointW-1:0]    point_c,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_data,
	output logic                          done,
	output logic signed [cts_pkg::ScoreW-1:0] score,
	output logic                          coincident_pair
);

	cts_pkg::mode_t mode_q;

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5;
	cts_pkg::mode_t               m_s1, m_s2, m_s3, m_s4, m_s5;
	logic [cts_pkg::PointW-1:0]   a_s1, b_s1, c_s1;
	cts_pkg::diff3_t              dab_s2, dbc_s2, dac_s2;
	logic [cts_pkg::DistW-1:0]    d12_s3, d23_s3, d13_s3;
	logic signed [cts_pkg::CrossW-1:0] x_s3 [3];
	logic                         z_s3, z_s4, z_s5;
	logic [cts_pkg::DistW-1:0]    d12_s4, d23_s4, d13_s4;
	logic [cts_pkg::AreaW-1:0]    area_s4;
	logic [cts_pkg::ProdW-1:0]    p12_s4, n0_s4, n1_s4, n2_s4;
	logic [cts_pkg::DenW-1:0]     den_s5;
	logic [cts_pkg::NumW-1:0]     num_s5;
	logic [cts_pkg::RadW-1:0]     rad_s5 [3];
	cts_pkg::iter_t               iter_s6 [cts_pkg::Steps];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cts_pkg::MODE_INVSQ;
		end else if (cfg_valid) begin
			mode_q <= cts_pkg::mode_t'(cfg_data);
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= point_a;
		b_s1 <= point_b;
		c_s1 <= point_c;
		m_s1 <= mode_q;
		m_s2 <= m_s1;
		m_s3 <= m_s2;
		m_s4 <= m_s3;
		m_s5 <= m_s4;
	end

	// channel differences, index 0 red
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dab_s2[i] <= $signed({1'b0, a_s1[(2-i)*8 +: 8]}) -
				$signed({1'b0, b_s1[(2-i)*8 +: 8]});
			dbc_s2[i] <= $signed({1'b0, b_s1[(2-i)*8 +: 8]}) -
				$signed({1'b0, c_s1[(2-i)*8 +: 8]});
			dac_s2[i] <= $signed({1'b0, a_s1[(2-i)*8 +: 8]}) -
				$signed({1'b0, c_s1[(2-i)*8 +: 8]});
		end
	end

	// squared distances and cross product of (c-a) and (b-a)
	always_ff @(posedge clk) begin
		logic [cts_pkg::DistW-1:0] s12, s23, s13;
		s12 = '0;
		s23 = '0;
		s13 = '0;
		for (int i = 0; i < 3; i++) begin
			s12 = s12 + cts_pkg::DistW'(unsigned'(cts_pkg::DistW'(dab_s2[i]) *
				cts_pkg::DistW'(dab_s2[i])));
			s23 = s23 + cts_pkg::DistW'(unsigned'(cts_pkg::DistW'(dbc_s2[i]) *
				cts_pkg::DistW'(dbc_s2[i])));
			s13 = s13 + cts_pkg::DistW'(unsigned'(cts_pkg::DistW'(dac_s2[i]) *
				cts_pkg::DistW'(dac_s2[i])));
		end
		d12_s3 <= s12;
		d23_s3 <= s23;
		d13_s3 <= s13;
		z_s3   <= (s12 == '0) || (s23 == '0) || (s13 == '0);
		x_s3[0] <= cts_pkg::CrossW'(dac_s2[1] * dab_s2[2]) - cts_pkg::CrossW'(dac_s2[2] * dab_s2[1]);
		x_s3[1] <= cts_pkg::CrossW'(dac_s2[2] * dab_s2[0]) - cts_pkg::CrossW'(dac_s2[0] * dab_s2[2]);
		x_s3[2] <= cts_pkg::CrossW'(dac_s2[0] * dab_s2[1]) - cts_pkg::CrossW'(dac_s2[1] * dab_s2[0]);
	end

	always_ff @(posedge clk) begin
		logic [cts_pkg::AreaW-1:0] acc;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			acc = acc + cts_pkg::AreaW'(unsigned'(cts_pkg::AreaW'(x_s3[i]) *
				cts_pkg::AreaW'(x_s3[i])));
		end
		area_s4 <= acc;
		p12_s4  <= cts_pkg::ProdW'(d12_s3) * cts_pkg::ProdW'(d23_s3);
		n0_s4   <= cts_pkg::ProdW'(d23_s3) * cts_pkg::ProdW'(d13_s3);
		n1_s4   <= cts_pkg::ProdW'(d12_s3) * cts_pkg::ProdW'(d13_s3);
		n2_s4   <= cts_pkg::ProdW'(d12_s3) * cts_pkg::ProdW'(d23_s3);
		d12_s4  <= d12_s3;
		d23_s4  <= d23_s3;
		d13_s4  <= d13_s3;
		z_s4    <= z_s3;
	end

	always_ff @(posedge clk) begin
		den_s5 <= cts_pkg::DenW'(p12_s4) * cts_pkg::DenW'(d13_s4);
		num_s5 <= cts_pkg::NumW'(n0_s4) + cts_pkg::NumW'(n1_s4) + cts_pkg::NumW'(n2_s4);
		z_s5   <= z_s4;
		if (m_s4 == cts_pkg::MODE_AREA) begin
			rad_s5[0] <= cts_pkg::RadW'(area_s4) << 30;
		end else begin
			rad_s5[0] <= cts_pkg::RadW'(d12_s4) << 32;
		end
		rad_s5[1] <= cts_pkg::RadW'(d23_s4) << 32;
		rad_s5[2] <= cts_pkg::RadW'(d13_s4) << 32;
	end

	// digit stages: one root bit per unit, and a quotient bit in the first stages
	for (genvar k = 0; k < cts_pkg::Steps; k++) begin : g_step
		cts_pkg::iter_t src;
		cts_pkg::iter_t nxt;

		if (k == 0) begin : g_first
			always_comb begin
				src       = '0;
				src.valid = v_s5;
				src.mode  = m_s5;
				src.flag  = z_s5;
				for (int u = 0; u < 3; u++) begin
					src.rad[u] = rad_s5[u];
				end
				src.drem  = cts_pkg::DivRemW'(num_s5) << cts_pkg::FracW;
				src.den   = den_s5;
			end
		end else begin : g_rest
			assign src = iter_s6[k-1];
		end

		always_comb begin
			logic [cts_pkg::RemW-1:0]    r;
			logic [cts_pkg::RemW-1:0]    t;
			logic [cts_pkg::DivRemW-1:0] sub;
			nxt = src;
			for (int u = 0; u < 3; u++) begin
				r = {src.rem[u][cts_pkg::RemW-3:0], src.rad[u][cts_pkg::RadW-1 -: 2]};
				t = cts_pkg::RemW'({src.root[u], 2'b01});
				nxt.rad[u] = src.rad[u] << 2;
				if (r >= t) begin
					nxt.rem[u]  = r - t;
					nxt.root[u] = {src.root[u][cts_pkg::RootW-2:0], 1'b1};
				end else begin
					nxt.rem[u]  = r;
					nxt.root[u] = {src.root[u][cts_pkg::RootW-2:0], 1'b0};
				end
			end
			sub = '0;
			if (k < cts_pkg::QuotW) begin
				sub = cts_pkg::DivRemW'(src.den) << (cts_pkg::QuotW - 1 - k);
				if (src.drem >= sub) begin
					nxt.drem = src.drem - sub;
					nxt.quot = src.quot | (cts_pkg::QuotW'(1) << (cts_pkg::QuotW - 1 - k));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				iter_s6[k] <= '0;
			end else begin
				iter_s6[k] <= nxt;
			end
		end
	end

	cts_pkg::iter_t last;
	assign last = iter_s6[cts_pkg::Steps-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		unique case (last.mode)
			cts_pkg::MODE_ZERO: begin
				score           <= '0;
				coincident_pair <= 1'b0;
			end
			cts_pkg::MODE_INVSQ: begin
				if (last.flag) begin
					score           <= {1'b1, {(cts_pkg::ScoreW-1){1'b0}}};
					coincident_pair <= 1'b1;
				end else begin
					score           <= -$signed(cts_pkg::ScoreW'(last.quot));
					coincident_pair <= 1'b0;
				end
			end
			cts_pkg::MODE_PERIM: begin
				score <= $signed(cts_pkg::ScoreW'(last.root[0]) +
					cts_pkg::ScoreW'(last.root[1]) + cts_pkg::ScoreW'(last.root[2]));
				coincident_pair <= 1'b0;
			end
			cts_pkg::MODE_AREA: begin
				score           <= $signed(cts_pkg::ScoreW'(last.root[0]));
				coincident_pair <= 1'b0;
			end
			default: begin
				score           <= '0;
				coincident_pair <= 1'b0;
			end
		endcase
	end

endmodule

### dv/tb_color_triangle_score_unit.sv
// ----------------------------------------------------------------------------
// tb_color_triangle_score_unit
// Self-checking bench for the colour triangle score unit. A queue of point
// triples is driven in random bursts with random gaps. The score mode is
// changed between phases while the pipeline is empty. Every strobed result is
// compared with a bit-exact integer prediction of the score and flag.
// ----------------------------------------------------------------------------
module tb_color_triangle_score_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [cts_pkg::PointW-1:0] a;
		logic [cts_pkg::PointW-1:0] b;
		logic [cts_pkg::PointW-1:0] c;
	} triple_t;

	typedef struct {
		logic signed [cts_pkg::ScoreW-1:0] score;
		logic                              flag;
	} score_res_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic [cts_pkg::PointW-1:0]        point_a = '0;
	logic [cts_pkg::PointW-1:0]        point_b = '0;
	logic [cts_pkg::PointW-1:0]        point_c = '0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [1:0]                        cfg_data = '0;
	logic                              done;
	logic signed [cts_pkg::ScoreW-1:0] score;
	logic                              coincident_pair;

	triple_t        pending_triples [$];
	score_res_t     expected_scores [$];
	cts_pkg::mode_t mode_writes [$];
	cts_pkg::mode_t active_mode = cts_pkg::MODE_INVSQ;
	int             gap_left = 0;
	int             burst_left = 0;
	int             errors = 0;

	color_triangle_score_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned dist_sq(logic [cts_pkg::PointW-1:0] p,
		logic [cts_pkg::PointW-1:0] q);
		longint unsigned s;
		longint d;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			d = longint'(p[8*k +: 8]) - longint'(q[8*k +: 8]);
			s += longint'(d * d);
		end
		return s;
	endfunction

	function automatic logic [63:0] root_floor(logic [127:0] v);
		logic [127:0] r;
		logic [127:0] bit_w;
		r = '0;
		bit_w = 128'd1 << 126;
		while (bit_w > v)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= r + bit_w) begin
				v = v - (r + bit_w);
				r = (r >> 1) + bit_w;
			end else begin
				r = r >> 1;
			end
			bit_w >>= 2;
		end
		return r[63:0];
	endfunction

	function automatic score_res_t triangle_score(triple_t t, cts_pkg::mode_t m);
		score_res_t res;
		longint unsigned dab, dbc, dac, num, den, q, r;
		longint u [3];
		longint w [3];
		longint x0, x1, x2;
		logic [127:0] cross_sq;
		dab = dist_sq(t.a, t.b);
		dbc = dist_sq(t.b, t.c);
		dac = dist_sq(t.a, t.c);
		res.score = '0;
		res.flag = 1'b0;
		case (m)
			cts_pkg::MODE_INVSQ: begin
				if (dab == 0 || dbc == 0 || dac == 0) begin
					res.score = {1'b1, {(cts_pkg::ScoreW-1){1'b0}}};
					res.flag = 1'b1;
				end else begin
					num = dbc * dac + dab * dac + dab * dbc;
					den = dab * dbc * dac;
					q = num / den;
					r = num % den;
					for (int i = 0; i < cts_pkg::FracW; i++) begin
						r = r << 1;
						q = q << 1;
						if (r >= den) begin
							r -= den;
							q |= 1;
						end
					end
					res.score = -q[cts_pkg::ScoreW-1:0];
				end
			end
			cts_pkg::MODE_PERIM: begin
				res.score = cts_pkg::ScoreW'(root_floor(128'(dab) << 32) +
					root_floor(128'(dbc) << 32) + root_floor(128'(dac) << 32));
			end
			cts_pkg::MODE_AREA: begin
				if (t.a != t.c) begin
					for (int i = 0; i < 3; i++) begin
						u[i] = longint'(t.c[16-8*i +: 8]) - longint'(t.a[16-8*i +: 8]);
						w[i] = longint'(t.b[16-8*i +: 8]) - longint'(t.a[16-8*i +: 8]);
					end
					x0 = u[1] * w[2] - u[2] * w[1];
					x1 = u[2] * w[0] - u[0] * w[2];
					x2 = u[0] * w[1] - u[1] * w[0];
					cross_sq = 128'(x0 * x0 + x1 * x1 + x2 * x2);
					res.score = cts_pkg::ScoreW'(root_floor(cross_sq << 30));
				end
			end
			default: res.score = '0;
		endcase
		return res;
	endfunction

	// driver: bursts of transactions separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		triple_t t;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!start || !busy) begin
			if (start)
				expected_scores.push_back(triangle_score('{point_a, point_b, point_c},
					active_mode));
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_triples.size() > 0) begin
				t = pending_triples.pop_front();
				point_a <= t.a;
				point_b <= t.b;
				point_c <= t.c;
				start <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(0, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// configuration channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			active_mode <= cts_pkg::mode_t'(cfg_data);
			cfg_valid <= 1'b0;
		end else if (!cfg_valid && mode_writes.size() > 0) begin
			cfg_data <= mode_writes.pop_front();
			cfg_valid <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		score_res_t e;
		if (arst_n && done) begin
			if (expected_scores.size() == 0) begin
				$display("%0t: unexpected transaction score=%0d flag=%0b", $realtime,
					score, coincident_pair);
				errors++;
			end else begin
				e = expected_scores.pop_front();
				if (score !== e.score) begin
					$display("%0t: score expected %0d actual %0d", $realtime, e.score, score);
					errors++;
				end
				if (coincident_pair !== e.flag) begin
					$display("%0t: coincident_pair expected %0b actual %0b", $realtime,
						e.flag, coincident_pair);
					errors++;
				end
			end
		end
	end

	function automatic logic [cts_pkg::PointW-1:0] rand_point();
		logic [cts_pkg::PointW-1:0] p;
		p = cts_pkg::PointW'($urandom());
		for (int k = 0; k < 3; k++)
			case ($urandom_range(0, 5))
				0: p[8*k +: 8] = 8'h00;
				1: p[8*k +: 8] = 8'hff;
				default: ;
			endcase
		return p;
	endfunction

	function automatic logic [cts_pkg::PointW-1:0] near_point(
		logic [cts_pkg::PointW-1:0] p);
		logic [cts_pkg::PointW-1:0] q;
		q = p;
		for (int k = 0; k < 3; k++)
			q[8*k +: 8] = p[8*k +: 8] + 8'($urandom_range(0, 4)) - 8'd2;
		return q;
	endfunction

	function automatic triple_t rand_triple();
		triple_t t;
		t.a = rand_point();
		t.b = rand_point();
		t.c = rand_point();
		case ($urandom_range(0, 9))
			0: t.b = t.a;
			1: t.c = t.b;
			2: t.c = t.a;
			3: begin
				t.b = near_point(t.a);
				t.c = near_point(t.a);
			end
			4: t.c = t.a + t.a - t.b;
			default: ;
		endcase
		return t;
	endfunction

	task automatic run_phase(cts_pkg::mode_t m, int n_rand);
		triple_t directed [$];
		mode_writes.push_back(m);
		while (mode_writes.size() != 0 || cfg_valid)
			@(posedge clk);
		@(posedge clk);
		directed = '{
			'{24'h000000, 24'h000000, 24'h000000},
			'{24'hffffff, 24'hffffff, 24'hffffff},
			'{24'h000000, 24'hffffff, 24'hff00ff},
			'{24'h123456, 24'h123456, 24'hfedcba},
			'{24'h123456, 24'hfedcba, 24'hfedcba},
			'{24'habcdef, 24'h010203, 24'habcdef},
			'{24'h000000, 24'h000001, 24'h000100},
			'{24'h000000, 24'hff0000, 24'h00ff00},
			'{24'h000000, 24'h808080, 24'hffffff},
			'{24'hff00ff, 24'h00ff00, 24'h000000}
		};
		foreach (directed[i])
			pending_triples.push_back(directed[i]);
		repeat (n_rand)
			pending_triples.push_back(rand_triple());
		while (pending_triples.size() != 0 || start || expected_scores.size() != 0)
			@(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_phase(cts_pkg::MODE_INVSQ, 450);
		run_phase(cts_pkg::MODE_ZERO, 150);
		run_phase(cts_pkg::MODE_PERIM, 400);
		run_phase(cts_pkg::MODE_AREA, 450);
		run_phase(cts_pkg::MODE_INVSQ, 200);
		run_phase(cts_pkg::MODE_AREA, 150);
		if (errors == 0 && expected_scores.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
